### hdl/bsc_pkg.sv
// Shared sizes, codes and field widths for the banker's safety check block.
// Used by the channel interfaces and the top level.
package bsc_pkg;

	// Sizing of the tables
	localparam int MAX_PROCESSES      = 16;
	localparam int MAX_RESOURCE_TYPES = 8;
	localparam int UNIT_WIDTH         = 16;

	localparam int PROC_W      = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int RES_W       = (MAX_RESOURCE_TYPES > 1) ? $clog2(MAX_RESOURCE_TYPES) : 1;
	localparam int ADDR_W      = PROC_W + RES_W;
	localparam int TABLE_DEPTH = 2 ** ADDR_W;
	// Signed work entries: total minus up to MAX_PROCESSES allocations
	localparam int WORK_W      = UNIT_WIDTH + PROC_W + 2;
	localparam int NPROC_W     = $clog2(MAX_PROCESSES + 1);
	localparam int NRES_W      = $clog2(MAX_RESOURCE_TYPES + 1);

	// Field widths fixed by the channel format
	localparam int KIND_W     = 2;
	localparam int PIDX_W     = 4;
	localparam int RIDX_W     = 3;
	localparam int AMOUNT_W   = 16;
	localparam int VERDICT_W  = 2;
	localparam int FINISHED_W = 5;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 5;
	localparam int PCOUNT_W    = 5;
	localparam int RCOUNT_W    = 4;
	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(16);
	localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = RCOUNT_W'(8);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PROCESS_COUNT       = 1'd0,
		CFG_RESOURCE_TYPE_COUNT = 1'd1
	} cfg_index_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_TOTAL = 2'd0,
		KIND_CLAIM = 2'd1,
		KIND_ALLOC = 2'd2,
		KIND_CHECK = 2'd3
	} kind_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_SAFE   = 2'd0,
		VERDICT_UNSAFE = 2'd1,
		VERDICT_ERROR  = 2'd2
	} verdict_t;

endpackage

### hdl/bsc_item_if.sv
// Input channel of the safety check: table loads and check requests.
// Depends on bsc_pkg for field widths.
interface bsc_item_if;
	logic                         valid;
	logic                         ready;
	logic [bsc_pkg::KIND_W-1:0]   kind;
	logic [bsc_pkg::PIDX_W-1:0]   process_index;
	logic [bsc_pkg::RIDX_W-1:0]   resource_index;
	logic [bsc_pkg::AMOUNT_W-1:0] amount;

	modport source (output valid, kind, process_index, resource_index, amount, input ready);
	modport sink (input valid, kind, process_index, resource_index, amount, output ready);
endinterface

### hdl/bsc_result_if.sv
// Result channel of the safety check: verdict and finished process count.
// Depends on bsc_pkg for field widths.
interface bsc_result_if;
	logic                           valid;
	logic                           ready;
	logic [bsc_pkg::VERDICT_W-1:0]  verdict;
	logic [bsc_pkg::FINISHED_W-1:0] finished_processes;

	modport source (output valid, verdict, finished_processes, input ready);
	modport sink (input valid, verdict, finished_processes, output ready);
endinterface

### hdl/bsc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/bankers_safety_check.sv
// Banker's algorithm safety check: claim and allocation tables in RAM,
// work vector and totals in registers. Depends on bsc_pkg, bsc_ram and the channel interfaces.
//
//   channel   dir  handshake     payload
//   item      in   valid/ready   kind, process_index, resource_index, amount
//   result    out  valid/ready   verdict, finished_processes
//   cfg       in   cfg_we        cfg_index, cfg_data
//
// Loads are taken back to back while idle.
// A check reads the tables at one (process, resource) entry per cycle through the RAM read
// port: one summing pass over all np*nr entries, then, unless a claim exceeds its total,
// walk passes, at most np of them, and then the result is posted.
// The posting cycle stretches while the previous result is still waiting to be taken.
// No item is taken while a check runs; loads resume as soon as its result is registered.
// Reset clears control state only; table contents are undefined until loaded.
module bankers_safety_check (
	input  logic                               clk,
	input  logic                               arst_n,
	bsc_item_if.sink                           item,
	bsc_result_if.source                       result,
	input  logic                               cfg_we,
	input  logic [bsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PW = bsc_pkg::PROC_W;
	localparam int RW = bsc_pkg::RES_W;
	localparam int UW = bsc_pkg::UNIT_WIDTH;
	localparam int WW = bsc_pkg::WORK_W;
	localparam int NPW = bsc_pkg::NPROC_W;
	localparam int NRW = bsc_pkg::NRES_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_WALK,
		S_RESULT
	} state_t;

	state_t state_q;

	// Configuration
	logic [bsc_pkg::PCOUNT_W-1:0] proc_count_q;
	logic [bsc_pkg::RCOUNT_W-1:0] res_count_q;
	logic [NPW-1:0]               np_clamped;
	logic [NRW-1:0]               nr_clamped;
	logic [NPW-1:0]               np_q;
	logic [PW-1:0]                np_last_q;
	logic [RW-1:0]                nr_last_q;

	// Issue counters and read stage
	logic          issue_q;
	logic [PW-1:0] p_q;
	logic [RW-1:0] r_q;
	logic          valid_s1;
	logic [PW-1:0] p_s1;
	logic [RW-1:0] r_s1;
	logic          last_r_s1;
	logic          last_s1;

	// Walk state
	logic                       err_q;
	logic                       fits_q;
	logic                       progress_q;
	logic [bsc_pkg::MAX_PROCESSES-1:0] done_q;
	logic [NPW-1:0]             finished_q;
	bsc_pkg::verdict_t          verdict_q;

	// Result register
	logic                            result_valid_q;
	bsc_pkg::verdict_t               result_verdict_q;
	logic [bsc_pkg::FINISHED_W-1:0]  result_count_q;
	logic                            post_result;

	// Datapath storage
	logic [UW-1:0]        total_q [bsc_pkg::MAX_RESOURCE_TYPES];
	logic signed [WW-1:0] work_q  [bsc_pkg::MAX_RESOURCE_TYPES];
	logic signed [WW-1:0] tmp_q   [bsc_pkg::MAX_RESOURCE_TYPES];

	// Load decode
	logic                       item_acc;
	logic                       idx_ok;
	logic                       we_total;
	logic                       we_claim;
	logic                       we_alloc;
	logic [bsc_pkg::ADDR_W-1:0] wr_addr;
	logic [bsc_pkg::ADDR_W-1:0] rd_addr;
	logic [UW-1:0]              claim_rd;
	logic [UW-1:0]              alloc_rd;

	// Per-entry datapath
	logic [UW-1:0]        total_sel;
	logic signed [WW-1:0] alloc_ext;
	logic signed [WW-1:0] claim_ext;
	logic signed [WW-1:0] sum_base;
	logic signed [WW-1:0] sum_next;
	logic signed [WW-1:0] walk_sum;
	logic                 claim_over;
	logic                 err_any;
	logic                 fits_now;
	logic                 commit;
	logic [NPW-1:0]       finished_next;

	assign item.ready = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;

	assign idx_ok = (32'(item.resource_index) < bsc_pkg::MAX_RESOURCE_TYPES)
		&& (32'(item.process_index) < bsc_pkg::MAX_PROCESSES);
	assign we_total = item_acc && (item.kind == bsc_pkg::KIND_TOTAL)
		&& (32'(item.resource_index) < bsc_pkg::MAX_RESOURCE_TYPES);
	assign we_claim = item_acc && (item.kind == bsc_pkg::KIND_CLAIM) && idx_ok;
	assign we_alloc = item_acc && (item.kind == bsc_pkg::KIND_ALLOC) && idx_ok;
	assign wr_addr  = {PW'(item.process_index), RW'(item.resource_index)};
	assign rd_addr  = {p_q, r_q};

	// Load the result register when it is empty or being taken
	assign post_result = (state_q == S_RESULT) && (!result_valid_q || result.ready);

	bsc_ram #(
		.WIDTH (UW),
		.DEPTH (bsc_pkg::TABLE_DEPTH)
	) u_claim_ram (
		.clk   (clk),
		.we    (we_claim),
		.waddr (wr_addr),
		.wdata (item.amount[UW-1:0]),
		.raddr (rd_addr),
		.rdata (claim_rd)
	);

	bsc_ram #(
		.WIDTH (UW),
		.DEPTH (bsc_pkg::TABLE_DEPTH)
	) u_alloc_ram (
		.clk   (clk),
		.we    (we_alloc),
		.waddr (wr_addr),
		.wdata (item.amount[UW-1:0]),
		.raddr (rd_addr),
		.rdata (alloc_rd)
	);

	// Zero count means one, above the table size means the table size
	always_comb begin
		if (proc_count_q == '0) begin
			np_clamped = NPW'(1);
		end else if (32'(proc_count_q) > bsc_pkg::MAX_PROCESSES) begin
			np_clamped = NPW'(bsc_pkg::MAX_PROCESSES);
		end else begin
			np_clamped = NPW'(proc_count_q);
		end
		if (res_count_q == '0) begin
			nr_clamped = NRW'(1);
		end else if (32'(res_count_q) > bsc_pkg::MAX_RESOURCE_TYPES) begin
			nr_clamped = NRW'(bsc_pkg::MAX_RESOURCE_TYPES);
		end else begin
			nr_clamped = NRW'(res_count_q);
		end
	end

	always_comb begin
		total_sel     = total_q[r_s1];
		alloc_ext     = $signed({{(WW-UW){1'b0}}, alloc_rd});
		claim_ext     = $signed({{(WW-UW){1'b0}}, claim_rd});
		sum_base      = (p_s1 == '0) ? $signed({{(WW-UW){1'b0}}, total_sel}) : work_q[r_s1];
		sum_next      = sum_base - alloc_ext;
		claim_over    = claim_rd > total_sel;
		err_any       = err_q || claim_over;
		// need <= work is the same as claim <= work + allocation
		walk_sum      = work_q[r_s1] + alloc_ext;
		fits_now      = ((r_s1 == '0) || fits_q) && (claim_ext <= walk_sum);
		commit        = valid_s1 && (state_q == S_WALK) && last_r_s1 && fits_now
			&& !done_q[p_s1];
		finished_next = finished_q + NPW'(commit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			proc_count_q     <= bsc_pkg::PCOUNT_RESET;
			res_count_q      <= bsc_pkg::RCOUNT_RESET;
			np_q             <= '0;
			np_last_q        <= '0;
			nr_last_q        <= '0;
			issue_q          <= 1'b0;
			p_q              <= '0;
			r_q              <= '0;
			valid_s1         <= 1'b0;
			p_s1             <= '0;
			r_s1             <= '0;
			last_r_s1        <= 1'b0;
			last_s1          <= 1'b0;
			err_q            <= 1'b0;
			fits_q           <= 1'b0;
			progress_q       <= 1'b0;
			done_q           <= '0;
			finished_q       <= '0;
			verdict_q        <= bsc_pkg::VERDICT_SAFE;
			result_valid_q   <= 1'b0;
			result_verdict_q <= bsc_pkg::VERDICT_SAFE;
			result_count_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bsc_pkg::CFG_PROCESS_COUNT:       proc_count_q <= cfg_data[bsc_pkg::PCOUNT_W-1:0];
					bsc_pkg::CFG_RESOURCE_TYPE_COUNT: res_count_q  <= cfg_data[bsc_pkg::RCOUNT_W-1:0];
					default: ;
				endcase
			end

			if (post_result) begin
				result_valid_q <= 1'b1;
			end else if (result.ready) begin
				result_valid_q <= 1'b0;
			end

			// Read stage: one table entry per cycle
			valid_s1 <= issue_q;
			if (issue_q) begin
				p_s1      <= p_q;
				r_s1      <= r_q;
				last_r_s1 <= (r_q == nr_last_q);
				last_s1   <= (r_q == nr_last_q) && (p_q == np_last_q);
				if (r_q == nr_last_q) begin
					r_q <= '0;
					if (p_q == np_last_q) begin
						p_q     <= '0;
						issue_q <= 1'b0;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end else begin
					r_q <= r_q + 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (item_acc && (item.kind == bsc_pkg::KIND_CHECK)) begin
						np_q      <= np_clamped;
						np_last_q <= PW'(np_clamped - 1'b1);
						nr_last_q <= RW'(nr_clamped - 1'b1);
						p_q       <= '0;
						r_q       <= '0;
						issue_q   <= 1'b1;
						err_q     <= 1'b0;
						state_q   <= S_SUM;
					end
				end
				S_SUM: begin
					if (valid_s1) begin
						err_q <= err_any;
						if (last_s1) begin
							if (err_any) begin
								verdict_q  <= bsc_pkg::VERDICT_ERROR;
								finished_q <= '0;
								state_q    <= S_RESULT;
							end else begin
								issue_q    <= 1'b1;
								done_q     <= '0;
								finished_q <= '0;
								progress_q <= 1'b0;
								state_q    <= S_WALK;
							end
						end
					end
				end
				S_WALK: begin
					if (valid_s1) begin
						fits_q <= fits_now;
						if (commit) begin
							done_q[p_s1] <= 1'b1;
							finished_q   <= finished_next;
						end
						if (last_s1) begin
							// another pass only if this one released something and a process is still unfinished
							if ((progress_q || commit) && (finished_next != np_q)) begin
								issue_q    <= 1'b1;
								progress_q <= 1'b0;
							end else begin
								verdict_q <= (finished_next == np_q) ? bsc_pkg::VERDICT_SAFE
									: bsc_pkg::VERDICT_UNSAFE;
								state_q   <= S_RESULT;
							end
						end else if (commit) begin
							progress_q <= 1'b1;
						end
					end
				end
				S_RESULT: begin
					// hold until the result register frees up
					if (post_result) begin
						result_verdict_q <= verdict_q;
						result_count_q   <= bsc_pkg::FINISHED_W'(finished_q);
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we_total) begin
			total_q[RW'(item.resource_index)] <= item.amount[UW-1:0];
		end
		if (valid_s1 && (state_q == S_SUM)) begin
			work_q[r_s1] <= sum_next;
		end
		if (valid_s1 && (state_q == S_WALK)) begin
			tmp_q[r_s1] <= walk_sum;
			if (commit) begin
				for (int i = 0; i < bsc_pkg::MAX_RESOURCE_TYPES; i++) begin
					work_q[i] <= (RW'(i) == r_s1) ? walk_sum : tmp_q[i];
				end
			end
		end
	end

	assign result.valid              = result_valid_q;
	assign result.verdict            = result_verdict_q;
	assign result.finished_processes = result_count_q;

	a_result_from_fsm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == S_RESULT))
		else $error("result posted outside the result state");

	a_read_stage_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == S_SUM || state_q == S_WALK))
		else $error("table read data outside a check");

	a_pass_end_stops_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |-> !issue_q)
		else $error("issue still running at the end of a pass");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> ($countones(done_q) == 32'(finished_q)))
		else $error("finished count disagrees with done flags");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for bankers_safety_check: table loads and safety checks in, verdicts out.
// Depends on bsc_pkg, bsc_item_if, bsc_result_if and the block itself.
module tb;

	localparam int TOTAL_ITEMS = 1850;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 16;
	localparam int LIMIT_NS = 500_000_000;
	localparam int REPORT_MAX = 10;

	localparam int KD_W  = bsc_pkg::KIND_W;
	localparam int PI_W  = bsc_pkg::PIDX_W;
	localparam int RI_W  = bsc_pkg::RIDX_W;
	localparam int AM_W  = bsc_pkg::AMOUNT_W;
	localparam int FIN_W = bsc_pkg::FINISHED_W;
	localparam int WK_W  = bsc_pkg::WORK_W;
	localparam int CD_W  = bsc_pkg::CFG_DATA_W;
	localparam int MAXP  = bsc_pkg::MAX_PROCESSES;
	localparam int MAXR  = bsc_pkg::MAX_RESOURCE_TYPES;

	// Short names for the directed table
	localparam bsc_pkg::cfg_index_t R_PC   = bsc_pkg::CFG_PROCESS_COUNT;
	localparam bsc_pkg::cfg_index_t R_RC   = bsc_pkg::CFG_RESOURCE_TYPE_COUNT;
	localparam bsc_pkg::kind_t      K_TOT  = bsc_pkg::KIND_TOTAL;
	localparam bsc_pkg::kind_t      K_CLM  = bsc_pkg::KIND_CLAIM;
	localparam bsc_pkg::kind_t      K_ALC  = bsc_pkg::KIND_ALLOC;
	localparam bsc_pkg::kind_t      K_CHK  = bsc_pkg::KIND_CHECK;
	localparam bsc_pkg::verdict_t   V_SAFE = bsc_pkg::VERDICT_SAFE;
	localparam bsc_pkg::verdict_t   V_UNSF = bsc_pkg::VERDICT_UNSAFE;
	localparam bsc_pkg::verdict_t   V_ERR  = bsc_pkg::VERDICT_ERROR;

	typedef struct packed {
		bsc_pkg::verdict_t      verdict;
		logic [FIN_W-1:0]       finished;
	} outcome_t;

	// One row of the directed part: a register write or an item, with an optional outcome
	typedef struct packed {
		logic                   cfg;
		bsc_pkg::cfg_index_t    reg_sel;
		logic [CD_W-1:0]        reg_val;
		bsc_pkg::kind_t         kind;
		logic [PI_W-1:0]        pidx;
		logic [RI_W-1:0]        ridx;
		logic [AM_W-1:0]        amount;
		logic                   typed;
		bsc_pkg::verdict_t      verdict;
		logic [FIN_W-1:0]       finished;
	} step_t;

	localparam step_t DIRECTED [26] = '{
		'{1, R_PC, 2, K_TOT, 0,  0, 0,     0, V_SAFE, 0},
		'{1, R_RC, 1, K_TOT, 0,  0, 0,     0, V_SAFE, 0},
		'{0, R_PC, 0, K_TOT, 0,  0, 10,    0, V_SAFE, 0},
		'{0, R_PC, 0, K_CLM, 0,  0, 10,    0, V_SAFE, 0},
		'{0, R_PC, 0, K_CLM, 1,  0, 4,     0, V_SAFE, 0},
		'{0, R_PC, 0, K_ALC, 0,  0, 5,     0, V_SAFE, 0},
		'{0, R_PC, 0, K_ALC, 1,  0, 2,     0, V_SAFE, 0},
		'{0, R_PC, 0, K_CHK, 0,  0, 0,     1, V_SAFE, 2},
		// repeat: tables survive a check, payload fields of a check are ignored
		'{0, R_PC, 0, K_CHK, 15, 7, 65535, 1, V_SAFE, 2},
		'{0, R_PC, 0, K_CLM, 1,  0, 11,    0, V_SAFE, 0},
		'{0, R_PC, 0, K_CHK, 0,  0, 0,     1, V_ERR,  0},
		'{0, R_PC, 0, K_CLM, 1,  0, 10,    0, V_SAFE, 0},
		'{0, R_PC, 0, K_CHK, 0,  0, 0,     1, V_UNSF, 0},
		// full-scale units, allocations far above the total drive work negative
		'{0, R_PC, 0, K_TOT, 0,  0, 65535, 0, V_SAFE, 0},
		'{0, R_PC, 0, K_CLM, 0,  0, 65535, 0, V_SAFE, 0},
		'{0, R_PC, 0, K_ALC, 0,  0, 65535, 0, V_SAFE, 0},
		'{0, R_PC, 0, K_ALC, 1,  0, 65535, 0, V_SAFE, 0},
		'{0, R_PC, 0, K_CHK, 0,  0, 0,     0, V_SAFE, 0},
		// zero-need process releases its allocation so the other one fits
		'{0, R_PC, 0, K_ALC, 1,  0, 0,     0, V_SAFE, 0},
		'{0, R_PC, 0, K_CHK, 0,  0, 0,     1, V_SAFE, 2},
		'{0, R_PC, 0, K_TOT, 0,  0, 0,     0, V_SAFE, 0},
		'{0, R_PC, 0, K_CHK, 0,  0, 0,     1, V_ERR,  0},
		// zero counts act as one
		'{1, R_PC, 0, K_TOT, 0,  0, 0,     0, V_SAFE, 0},
		'{1, R_RC, 0, K_TOT, 0,  0, 0,     0, V_SAFE, 0},
		'{0, R_PC, 0, K_TOT, 0,  0, 65535, 0, V_SAFE, 0},
		'{0, R_PC, 0, K_CHK, 0,  0, 0,     1, V_SAFE, 1}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	bsc_pkg::cfg_index_t cfg_index;
	logic [CD_W-1:0] cfg_data;

	bsc_item_if item_ch ();
	bsc_result_if result_ch ();

	bankers_safety_check DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the block's tables and count registers
	logic [bsc_pkg::UNIT_WIDTH-1:0] units_total [MAXR];
	logic [bsc_pkg::UNIT_WIDTH-1:0] claims [MAXP][MAXR];
	logic [bsc_pkg::UNIT_WIDTH-1:0] allocs [MAXP][MAXR];
	logic [bsc_pkg::PCOUNT_W-1:0] proc_count = bsc_pkg::PCOUNT_RESET;
	logic [bsc_pkg::RCOUNT_W-1:0] res_count = bsc_pkg::RCOUNT_RESET;

	outcome_t pending_verdicts [$];
	bit calm_phase;
	int items_sent;
	int checks_sent;
	int reg_writes;
	int faults;
	int verdict_tally [3];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int clamp_count(input int v, input int top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	// Banker's safety walk over the shadow tables
	function automatic outcome_t safety_verdict();
		int np;
		int nr;
		int p;
		int r;
		int done_cnt;
		logic signed [WK_W-1:0] work [MAXR];
		logic signed [WK_W-1:0] need;
		logic [MAXP-1:0] done;
		logic fits;
		logic progress;
		outcome_t o;

		np = clamp_count(int'(proc_count), MAXP);
		nr = clamp_count(int'(res_count), MAXR);
		done = '0;
		done_cnt = 0;
		for (r = 0; r < nr; r++) begin
			work[r] = $signed(WK_W'(units_total[r]));
			for (p = 0; p < np; p++) begin
				if (claims[p][r] > units_total[r]) begin
					o.verdict = bsc_pkg::VERDICT_ERROR;
					o.finished = '0;
					return o;
				end
				work[r] = work[r] - $signed(WK_W'(allocs[p][r]));
			end
		end
		do begin
			progress = 1'b0;
			for (p = 0; p < np; p++) begin
				if (!done[p]) begin
					fits = 1'b1;
					for (r = 0; r < nr; r++) begin
						need = $signed(WK_W'(claims[p][r])) - $signed(WK_W'(allocs[p][r]));
						if (need > work[r]) begin
							fits = 1'b0;
							break;
						end
					end
					if (fits) begin
						for (r = 0; r < nr; r++)
							work[r] = work[r] + $signed(WK_W'(allocs[p][r]));
						done[p] = 1'b1;
						done_cnt++;
						progress = 1'b1;
					end
				end
			end
		end while (progress);
		o.verdict = (done_cnt == np) ? bsc_pkg::VERDICT_SAFE : bsc_pkg::VERDICT_UNSAFE;
		o.finished = FIN_W'(done_cnt);
		return o;
	endfunction

	// Present one item, hold it until taken, then update the shadow state
	task automatic send(input bsc_pkg::kind_t k, input logic [PI_W-1:0] p,
			input logic [RI_W-1:0] r, input logic [AM_W-1:0] a, input bit modeled);
		int unsigned gap;

		gap = calm_phase ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.process_index <= p;
		item_ch.resource_index <= r;
		item_ch.amount <= a;
		do @(posedge clk); while (!(item_ch.valid === 1'b1 && item_ch.ready === 1'b1));
		items_sent++;
		case (k)
			bsc_pkg::KIND_TOTAL: units_total[r] = a;
			bsc_pkg::KIND_CLAIM: claims[p][r] = a;
			bsc_pkg::KIND_ALLOC: allocs[p][r] = a;
			default: begin
				checks_sent++;
				if (modeled)
					pending_verdicts.push_back(safety_verdict());
			end
		endcase
	endtask

	// Drop valid, wait for every verdict, then let trailing loads settle
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input bsc_pkg::cfg_index_t sel, input logic [CD_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == bsc_pkg::CFG_PROCESS_COUNT)
			proc_count = bsc_pkg::PCOUNT_W'(val);
		else
			res_count = bsc_pkg::RCOUNT_W'(val);
		reg_writes++;
	endtask

	// One random burst: mostly a consistent table set followed by checks, else edits or noise
	task automatic load_and_check();
		int np;
		int nr;
		int style;
		int p;
		int r;
		int n;
		int cap;
		int tot;
		int al;
		int cl;
		int spoil;

		np = clamp_count(int'(proc_count), MAXP);
		nr = clamp_count(int'(res_count), MAXR);
		style = $urandom_range(0, 9);
		if (style <= 6) begin
			cap = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(1, 40);
			spoil = ($urandom_range(0, 5) == 0) ? $urandom_range(0, np * nr - 1) : -1;
			for (r = 0; r < nr; r++) begin
				tot = (cap == 65535 && $urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, cap);
				send(bsc_pkg::KIND_TOTAL, PI_W'($urandom), RI_W'(r), AM_W'(tot), 1'b1);
				for (p = 0; p < np; p++) begin
					al = $urandom_range(0, (2 * tot) / np);
					if (al > tot)
						al = tot;
					cl = al + $urandom_range(0, tot - al);
					// overclaim one entry, or hand out more than was claimed
					if (p * nr + r == spoil && tot < 65535)
						cl = tot + 1;
					else if ($urandom_range(0, 29) == 0)
						al = (cl + 100 > 65535) ? 65535 : cl + $urandom_range(1, 100);
					send(bsc_pkg::KIND_CLAIM, PI_W'(p), RI_W'(r), AM_W'(cl), 1'b1);
					send(bsc_pkg::KIND_ALLOC, PI_W'(p), RI_W'(r), AM_W'(al), 1'b1);
				end
			end
			n = $urandom_range(1, 2);
		end else if (style <= 8) begin
			repeat ($urandom_range(1, 4))
				send(bsc_pkg::kind_t'(KD_W'($urandom_range(0, 2))),
					PI_W'($urandom_range(0, np - 1)),
					RI_W'($urandom_range(0, nr - 1)),
					AM_W'(($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 40)),
					1'b1);
			n = 1;
		end else begin
			repeat ($urandom_range(1, 6))
				send(bsc_pkg::kind_t'(KD_W'($urandom_range(0, 2))), PI_W'($urandom),
					RI_W'($urandom), AM_W'($urandom), 1'b1);
			n = $urandom_range(0, 1);
		end
		repeat (n)
			send(bsc_pkg::KIND_CHECK, PI_W'($urandom), RI_W'($urandom), AM_W'($urandom), 1'b1);
	endtask

	// Result side: random stall before each verdict, none in calm phases
	initial begin : take_results
		int unsigned stall;

		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm_phase ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
		end
	end

	always @(posedge clk) begin : score
		outcome_t want;

		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (result_ch.verdict <= bsc_pkg::VERDICT_ERROR)
				verdict_tally[result_ch.verdict]++;
			if (pending_verdicts.size() == 0) begin
				faults++;
				if (faults <= REPORT_MAX)
					$display("%0t: verdict %0d finished %0d with no check outstanding",
						$time, result_ch.verdict, result_ch.finished_processes);
			end else begin
				want = pending_verdicts.pop_front();
				if (result_ch.verdict !== want.verdict
						|| result_ch.finished_processes !== want.finished) begin
					faults++;
					if (faults <= REPORT_MAX)
						$display("%0t: verdict exp %0d got %0d, finished exp %0d got %0d",
							$time, want.verdict, result_ch.verdict,
							want.finished, result_ch.finished_processes);
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("%0t: timeout with %0d verdicts outstanding", $time, pending_verdicts.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int i;
		int p;
		int r;
		int phase;
		int start;
		int budget;
		logic [CD_W-1:0] pc_val;
		logic [CD_W-1:0] rc_val;
		step_t row;
		outcome_t typed_out;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= bsc_pkg::CFG_PROCESS_COUNT;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.kind <= bsc_pkg::KIND_TOTAL;
		item_ch.process_index <= '0;
		item_ch.resource_index <= '0;
		item_ch.amount <= '0;
		calm_phase = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(DIRECTED); i++) begin
			row = DIRECTED[i];
			if (row.cfg) begin
				settle();
				write_reg(row.reg_sel, row.reg_val);
			end else begin
				send(row.kind, row.pidx, row.ridx, row.amount, !row.typed);
				if (row.typed) begin
					typed_out.verdict = row.verdict;
					typed_out.finished = row.finished;
					pending_verdicts.push_back(typed_out);
				end
			end
		end

		// Fill every entry so that any count setting reads written data only
		for (r = 0; r < MAXR; r++)
			send(bsc_pkg::KIND_TOTAL, PI_W'($urandom), RI_W'(r), AM_W'($urandom), 1'b1);
		for (p = 0; p < MAXP; p++)
			for (r = 0; r < MAXR; r++) begin
				send(bsc_pkg::KIND_CLAIM, PI_W'(p), RI_W'(r), AM_W'($urandom), 1'b1);
				send(bsc_pkg::KIND_ALLOC, PI_W'(p), RI_W'(r), AM_W'($urandom), 1'b1);
			end

		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			settle();
			case (phase)
				0: begin
					pc_val = 31;
					rc_val = 15;
				end
				1: begin
					pc_val = CD_W'(MAXP);
					rc_val = CD_W'(MAXR);
				end
				2: begin
					pc_val = 1;
					rc_val = 1;
				end
				3: begin
					pc_val = 0;
					rc_val = 0;
				end
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						pc_val = CD_W'($urandom_range(9, 31));
						rc_val = CD_W'($urandom_range(5, 15));
					end else begin
						pc_val = CD_W'($urandom_range(0, 6));
						rc_val = CD_W'($urandom_range(0, 3));
					end
				end
			endcase
			write_reg(bsc_pkg::CFG_PROCESS_COUNT, pc_val);
			write_reg(bsc_pkg::CFG_RESOURCE_TYPE_COUNT, rc_val);
			calm_phase = ($urandom_range(0, 3) == 0);
			budget = $urandom_range(30, 80);
			start = items_sent;
			while (items_sent - start < budget)
				load_and_check();
			phase++;
		end

		calm_phase = 1'b0;
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d items and %0d checks over %0d register writes.",
			items_sent, checks_sent, reg_writes);
		$display("Verdicts seen: %0d safe, %0d unsafe, %0d error; %0d mismatches.",
			verdict_tally[bsc_pkg::VERDICT_SAFE], verdict_tally[bsc_pkg::VERDICT_UNSAFE],
			verdict_tally[bsc_pkg::VERDICT_ERROR], faults);
		if (faults == 0 && pending_verdicts.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
